[design/minstd_random_range_draw_macros.svh]
// Assertion helpers used by the top-level design file.
`ifndef MINSTD_RANDOM_RANGE_DRAW_MACROS_SVH
`define MINSTD_RANDOM_RANGE_DRAW_MACROS_SVH

// Same-cycle implication.
`define MRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mrd_pkg.sv]
package mrd_pkg;

    typedef enum logic [1:0] {
        CMD_INT  = 2'd0,
        CMD_FRAC = 2'd1,
        CMD_SEED = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [31:0] LCG_MULT    = 32'd48271;
    localparam logic [31:0] LCG_MOD     = 32'h7fffffff;
    localparam logic [30:0] LCG_RESEED  = 31'h1234;
    localparam logic [30:0] LCG_MAX     = 31'h7fffffff;
    localparam logic [30:0] HI27_MASK   = 31'h1ffffffc;
    localparam logic [30:0] LO26_MASK   = 31'h1ffffff8;
    localparam logic [30:0] FRAC24_MASK = 31'h0ffffff0;
    localparam logic [31:0] SEED_MASK   = 32'h7fffffff;

    typedef struct packed {
        logic load;
        logic prep;
        logic lcg_mul;
        logic lcg_fold;
        logic mul_lo;
        logic mul_hi;
        logic mul_frac;
        logic sum;
        logic fin;
        logic load_out;
        logic first;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
    } stat_t;

endpackage

[design/mrd_if.sv]
interface mrd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [31:0]        seed_value;

    modport source (output valid, cmd, low_bound, high_bound, seed_value, input ready);
    modport sink (input valid, cmd, low_bound, high_bound, seed_value, output ready);
endinterface

interface mrd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] draw_value;
    logic [30:0]        generator_state;

    modport source (output valid, draw_value, generator_state, input ready);
    modport sink (input valid, draw_value, generator_state, output ready);
endinterface

[design/minstd_random_range_draw.sv]
// Minimal-standard (multiplier 48271, modulus 2^31-1) random range generator. One request beat
// carries a command: integer draw in an inclusive range (bounds swapped if reversed, two
// generator steps), Q16.16 draw between two bounds (one step), or reseed. Each request returns
// exactly one response beat with the draw (zero for reseed or the unused command) and the
// generator state after the command. The generator resets to 0x1234. All arithmetic runs on
// one shared 32x32 multiplier followed by a Mersenne fold. A finished item holds in its last
// step while the previous response beat still waits. The request side is ready again at the
// edge that loads the response, and a pending response does not block the next request from
// being accepted.
`include "minstd_random_range_draw_macros.svh"

module minstd_random_range_draw (
    input logic       clk,
    input logic       rst_n,
    mrd_req_if.sink   req,
    mrd_rsp_if.source rsp
);

    mrd_pkg::ctrl_t ctrl;
    mrd_pkg::stat_t stat;
    logic [8:0]     step_vec;
    logic           state_ok;

    mrd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    mrd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .cmd             (req.cmd),
        .low_bound       (req.low_bound),
        .high_bound      (req.high_bound),
        .seed_value      (req.seed_value),
        .draw_value      (rsp.draw_value),
        .generator_state (rsp.generator_state)
    );

    assign step_vec = {ctrl.prep, ctrl.lcg_mul, ctrl.lcg_fold, ctrl.mul_lo, ctrl.mul_hi,
                       ctrl.mul_frac, ctrl.sum, ctrl.fin, ctrl.load_out};
    assign state_ok = (rsp.generator_state != 31'd0) &&
                      (rsp.generator_state != mrd_pkg::LCG_MAX);

    `MRD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `MRD_ASSERT_NOW(a_state_legal, rsp.valid, state_ok, "illegal state")
    `MRD_ASSERT_NOW(a_no_overwrite, ctrl.load_out, !rsp.valid || rsp.ready, "response overwritten")
    `MRD_ASSERT_NOW(a_one_step, 1'b1, $onehot0(step_vec), "steps overlap")

endmodule

[design/mrd_mul.sv]
module mrd_mul (
    input  mrd_pkg::ctrl_t ctrl,
    input  logic [30:0]    lcg,
    input  logic [30:0]    s1,
    input  logic [32:0]    opb,
    output logic [63:0]    prod
);

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [30:0] frac_bits;
    logic [63:0] mul_full;
    logic        wide;

    always_comb
    begin
        frac_bits = lcg & mrd_pkg::FRAC24_MASK;
        mul_b     = opb[31:0];
        priority if (ctrl.lcg_mul)
        begin
            mul_a = {1'b0, lcg};
            mul_b = mrd_pkg::LCG_MULT;
        end
        else if (ctrl.mul_lo)
        begin
            mul_a = {1'b0, lcg & mrd_pkg::LO26_MASK};
        end
        else if (ctrl.mul_hi)
        begin
            mul_a = {1'b0, s1 & mrd_pkg::HI27_MASK};
        end
        else
        begin
            mul_a = {8'd0, frac_bits[27:4]};
        end
    end

    assign mul_full = mul_a * mul_b;
    // a full 2^32 range has zero low word: the product is a plain shift
    assign wide = opb[32] && (ctrl.mul_lo || ctrl.mul_hi);
    assign prod = wide ? {mul_a, 32'd0} : mul_full;

endmodule

[design/mrd_seq.sv]
module mrd_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mrd_pkg::stat_t stat,
    output mrd_pkg::ctrl_t ctrl
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PREP   = 10'b00_0000_0010,
        S_LMUL   = 10'b00_0000_0100,
        S_LFOLD  = 10'b00_0000_1000,
        S_MLO    = 10'b00_0001_0000,
        S_MHI    = 10'b00_0010_0000,
        S_MFRAC  = 10'b00_0100_0000,
        S_SUM    = 10'b00_1000_0000,
        S_FIN    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        ctrl       = '0;
        ctrl.first = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                ctrl.prep = 1'b1;
                if (stat.cmd == mrd_pkg::CMD_INT || stat.cmd == mrd_pkg::CMD_FRAC)
                begin
                    first_next = 1'b1;
                    state_next = S_LMUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LMUL:
            begin
                ctrl.lcg_mul = 1'b1;
                state_next   = S_LFOLD;
            end
            S_LFOLD:
            begin
                ctrl.lcg_fold = 1'b1;
                first_next    = 1'b0;
                if (stat.cmd == mrd_pkg::CMD_FRAC)
                begin
                    state_next = S_MFRAC;
                end
                else if (first_reg)
                begin
                    state_next = S_LMUL;
                end
                else
                begin
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                ctrl.mul_lo = 1'b1;
                state_next  = S_MHI;
            end
            S_MHI:
            begin
                ctrl.mul_hi = 1'b1;
                state_next  = S_SUM;
            end
            S_MFRAC:
            begin
                ctrl.mul_frac = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                ctrl.sum   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ctrl.fin   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/mrd_datapath.sv]
module mrd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mrd_pkg::ctrl_t     ctrl,
    output mrd_pkg::stat_t     stat,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    input  logic [31:0]        seed_value,
    output logic signed [31:0] draw_value,
    output logic [30:0]        generator_state
);

    mrd_pkg::cmd_t      cmd_reg, cmd_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;
    logic [31:0]        seed_reg, seed_next;
    logic signed [32:0] diff_reg, diff_next;
    logic [32:0]        opb_reg, opb_next;
    logic [30:0]        s1_reg, s1_next;
    logic [30:0]        lcg_reg, lcg_next;
    logic [63:0]        prod_reg, prod_next;
    logic [33:0]        acc_reg, acc_next;
    logic signed [33:0] q_reg, q_next;
    logic signed [31:0] draw_reg, draw_next;
    logic signed [31:0] draw_out_reg, draw_out_next;
    logic [30:0]        gen_out_reg, gen_out_next;

    logic [63:0]        mul_prod;
    logic               is_int;
    logic               neg;
    logic signed [32:0] diff_calc;
    logic [32:0]        opb_base;
    logic [32:0]        opb_inc;
    logic [31:0]        fold_sum;
    logic [31:0]        fold_val;
    logic [31:0]        seed_masked;
    logic [30:0]        seed_val;
    logic [61:0]        total;
    logic signed [56:0] mag_s;
    logic signed [56:0] frac_p;
    logic signed [33:0] res;
    logic signed [33:0] hi_ext;

    mrd_mul u_mul (
        .ctrl (ctrl),
        .lcg  (lcg_reg),
        .s1   (s1_reg),
        .opb  (opb_reg),
        .prod (mul_prod)
    );

    assign is_int = (cmd_reg == mrd_pkg::CMD_INT);
    assign neg    = diff_reg[32];

    always_comb
    begin
        diff_calc   = $signed({hi_reg[31], hi_reg}) - $signed({lo_reg[31], lo_reg});
        opb_base    = neg ? ~diff_reg : diff_reg;
        opb_inc     = is_int ? (neg ? 33'd2 : 33'd1) : (neg ? 33'd1 : 33'd0);
        fold_sum    = {16'd0, prod_reg[46:31]} + {1'b0, prod_reg[30:0]};
        fold_val    = (fold_sum >= mrd_pkg::LCG_MOD) ? fold_sum - mrd_pkg::LCG_MOD : fold_sum;
        seed_masked = seed_reg & mrd_pkg::SEED_MASK;
        seed_val    = seed_masked[30:0];
        if (seed_val == 31'd0 || seed_val == mrd_pkg::LCG_MAX)
        begin
            seed_val = mrd_pkg::LCG_RESEED;
        end
        total  = {1'b0, prod_reg[60:0]} + {28'd0, acc_reg};
        mag_s  = {1'b0, prod_reg[55:0]};
        frac_p = neg ? -mag_s : mag_s;
        res    = $signed({{2{lo_reg[31]}}, lo_reg}) + q_reg;
        hi_ext = $signed({{2{hi_reg[31]}}, hi_reg});
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        seed_next     = seed_reg;
        diff_next     = diff_reg;
        opb_next      = opb_reg;
        s1_next       = s1_reg;
        lcg_next      = lcg_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        q_next        = q_reg;
        draw_next     = draw_reg;
        draw_out_next = draw_out_reg;
        gen_out_next  = gen_out_reg;

        if (ctrl.load)
        begin
            cmd_next  = mrd_pkg::cmd_t'(cmd);
            lo_next   = low_bound;
            hi_next   = high_bound;
            seed_next = seed_value;
        end
        if (ctrl.prep)
        begin
            diff_next = diff_calc;
            draw_next = 32'sd0;
            // swap reversed bounds for an integer draw
            if (is_int && diff_calc[32])
            begin
                lo_next = hi_reg;
                hi_next = lo_reg;
            end
            if (cmd_reg == mrd_pkg::CMD_SEED)
            begin
                lcg_next = seed_val;
            end
        end
        if (ctrl.lcg_mul)
        begin
            prod_next = mul_prod;
            if (ctrl.first)
            begin
                opb_next = opb_base + opb_inc;
            end
        end
        if (ctrl.lcg_fold)
        begin
            lcg_next = fold_val[30:0];
            if (ctrl.first)
            begin
                s1_next = fold_val[30:0];
            end
        end
        if (ctrl.mul_lo || ctrl.mul_frac)
        begin
            prod_next = mul_prod;
        end
        if (ctrl.mul_hi)
        begin
            acc_next  = prod_reg[60:27];
            prod_next = mul_prod;
        end
        if (ctrl.sum)
        begin
            q_next = is_int ? $signed({1'b0, total[61:29]}) : $signed({frac_p[56], frac_p[56:24]});
        end
        if (ctrl.fin)
        begin
            draw_next = (is_int && res > hi_ext) ? hi_reg : res[31:0];
        end
        if (ctrl.load_out)
        begin
            draw_out_next = draw_reg;
            gen_out_next  = lcg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg <= mrd_pkg::LCG_RESEED;
        end
        else
        begin
            lcg_reg <= lcg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        seed_reg     <= seed_next;
        diff_reg     <= diff_next;
        opb_reg      <= opb_next;
        s1_reg       <= s1_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        q_reg        <= q_next;
        draw_reg     <= draw_next;
        draw_out_reg <= draw_out_next;
        gen_out_reg  <= gen_out_next;
    end

    assign stat.cmd        = cmd_reg;
    assign draw_value      = draw_out_reg;
    assign generator_state = gen_out_reg;

endmodule
